[rtl/csp_pkg.sv]
`timescale 1ns / 1ps

package csp_pkg;

    typedef logic [7:0] char_t;
    typedef logic [7:0] chan_t;
    typedef logic [1:0] form_t;

    // Result forms
    localparam form_t FORM_HEX6 = 2'd0;
    localparam form_t FORM_HEX3 = 2'd1;
    localparam form_t FORM_RGB  = 2'd2;
    localparam form_t FORM_NONE = 2'd3;

    // Character codes that steer the parse
    localparam char_t CH_HASH   = 8'h23;
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_COMMA  = 8'h2C;
    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_TAB    = 8'h09;
    localparam char_t CH_CR     = 8'h0D;
    localparam char_t CH_ZERO   = 8'h30;
    localparam char_t CH_NINE   = 8'h39;
    localparam char_t CH_UA     = 8'h41;
    localparam char_t CH_UB     = 8'h42;
    localparam char_t CH_UF     = 8'h46;
    localparam char_t CH_UG     = 8'h47;
    localparam char_t CH_UR     = 8'h52;
    localparam char_t CH_LA     = 8'h61;
    localparam char_t CH_LZ     = 8'h7A;
    localparam char_t CASE_GAP  = 8'h20;

endpackage

[rtl/csp_if.sv]
`timescale 1ns / 1ps

interface csp_in_if
    import csp_pkg::*;
();
    logic  valid;
    logic  ready;
    char_t char_code;
    logic  last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface csp_out_if
    import csp_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  matched;
    form_t form;
    chan_t red;
    chan_t green;
    chan_t blue;

    modport source (output valid, output matched, output form, output red, output green,
                    output blue, input ready);
    modport sink   (input valid, input matched, input form, input red, input green,
                    input blue, output ready);
endinterface

[rtl/color_string_parser.sv]
`timescale 1ns / 1ps
// Path: a last character is held in the input register, then the parse logic writes the
// result register once the result slot is free; the parse state updates in a single pass.
// Throughput: one character per cycle unless a last character waits for a full result slot.
// Reset: rst_n clears both valid flags and the whole parse state to start of string.
// After every last character the parse state returns to start of string.
module color_string_parser
    import csp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    csp_in_if.sink          chars,
    csp_out_if.source       colors
);

    localparam logic [3:0] PH_START    = 4'd0;
    localparam logic [3:0] PH_HASH     = 4'd1;
    localparam logic [3:0] PH_HEX      = 4'd2;
    localparam logic [3:0] PH_R        = 4'd3;
    localparam logic [3:0] PH_RG       = 4'd4;
    localparam logic [3:0] PH_RGB      = 4'd5;
    localparam logic [3:0] PH_PRE_NUM  = 4'd6;
    localparam logic [3:0] PH_NUM      = 4'd7;
    localparam logic [3:0] PH_POST_NUM = 4'd8;
    localparam logic [3:0] PH_CLOSED   = 4'd9;
    localparam logic [3:0] PH_FAIL     = 4'd10;

    // Input register
    logic        stage_valid_reg;
    char_t       char_reg;
    logic        last_reg;

    // Parse state
    logic [3:0]  phase_reg,     phase_next;
    logic [2:0]  hex_cnt_reg,   hex_cnt_next;
    logic [23:0] hex_acc_reg,   hex_acc_next;
    logic [9:0]  dec_acc_reg,   dec_acc_next;
    logic [1:0]  dec_cnt_reg,   dec_cnt_next;
    logic [1:0]  chan_idx_reg,  chan_idx_next;
    chan_t       red_hold_reg,  red_hold_next;
    chan_t       green_hold_reg, green_hold_next;

    // Result register
    logic        out_valid_reg;
    logic        matched_reg,   matched_next;
    form_t       form_reg,      form_next;
    chan_t       red_reg,       red_next;
    chan_t       green_reg,     green_next;
    chan_t       blue_reg,      blue_next;

    logic        out_free;
    logic        step;
    char_t       c;
    logic        is_hex;
    logic [3:0]  hex_val;
    logic        is_digit;
    logic        is_space;
    logic [3:0]  digit_val;
    logic [9:0]  dec_mac;

    // Handshake: the stage moves on unless a last character waits for a full result slot
    assign out_free    = !out_valid_reg || colors.ready;
    assign step        = stage_valid_reg && (!last_reg || out_free);
    assign chars.ready = !stage_valid_reg || step;

    assign colors.valid   = out_valid_reg;
    assign colors.matched = matched_reg;
    assign colors.form    = form_reg;
    assign colors.red     = red_reg;
    assign colors.green   = green_reg;
    assign colors.blue    = blue_reg;

    // Fold case and classify the character
    always_comb
    begin
        c = char_reg;
        if (char_reg >= CH_LA && char_reg <= CH_LZ)
        begin
            c = char_reg - CASE_GAP;
        end
        is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
        is_space  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        digit_val = 4'(c - CH_ZERO);
        is_hex    = is_digit || ((c >= CH_UA) && (c <= CH_UF));
        hex_val   = is_digit ? digit_val : 4'(c - CH_UA + 8'd10);
        dec_mac   = 10'((dec_acc_reg << 3) + (dec_acc_reg << 1)) + {6'd0, digit_val};
    end

    // Advance the parse state by one character
    always_comb
    begin
        phase_next      = phase_reg;
        hex_cnt_next    = hex_cnt_reg;
        hex_acc_next    = hex_acc_reg;
        dec_acc_next    = dec_acc_reg;
        dec_cnt_next    = dec_cnt_reg;
        chan_idx_next   = chan_idx_reg;
        red_hold_next   = red_hold_reg;
        green_hold_next = green_hold_reg;

        unique case (phase_reg)
            PH_START, PH_HASH, PH_HEX:
            begin
                if (phase_reg == PH_START && c == CH_HASH)
                begin
                    phase_next = PH_HASH;
                end
                else if (phase_reg == PH_START && c == CH_UR)
                begin
                    phase_next = PH_R;
                end
                else if (is_hex && hex_cnt_reg < 3'd6)
                begin
                    hex_acc_next = {hex_acc_reg[19:0], hex_val};
                    hex_cnt_next = hex_cnt_reg + 3'd1;
                    phase_next   = PH_HEX;
                end
                else
                begin
                    phase_next = PH_FAIL;
                end
            end
            PH_R:   phase_next = (c == CH_UG) ? PH_RG : PH_FAIL;
            PH_RG:  phase_next = (c == CH_UB) ? PH_RGB : PH_FAIL;
            PH_RGB: phase_next = (c == CH_LPAREN) ? PH_PRE_NUM : PH_FAIL;
            PH_PRE_NUM:
            begin
                if (is_digit)
                begin
                    dec_acc_next = {6'd0, digit_val};
                    dec_cnt_next = 2'd1;
                    phase_next   = PH_NUM;
                end
                else if (!is_space)
                begin
                    phase_next = PH_FAIL;
                end
            end
            PH_NUM, PH_POST_NUM:
            begin
                if (phase_reg == PH_NUM && is_digit)
                begin
                    if (dec_cnt_reg < 2'd3)
                    begin
                        dec_acc_next = dec_mac;
                        dec_cnt_next = dec_cnt_reg + 2'd1;
                    end
                    else
                    begin
                        phase_next = PH_FAIL;
                    end
                end
                else if (is_space)
                begin
                    phase_next = PH_POST_NUM;
                end
                else if (c == CH_COMMA && chan_idx_reg < 2'd2)
                begin
                    // close a channel and start the next number
                    if (chan_idx_reg == 2'd0)
                    begin
                        red_hold_next = dec_acc_reg[7:0];
                    end
                    else
                    begin
                        green_hold_next = dec_acc_reg[7:0];
                    end
                    chan_idx_next = chan_idx_reg + 2'd1;
                    dec_acc_next  = '0;
                    dec_cnt_next  = '0;
                    phase_next    = PH_PRE_NUM;
                end
                else if (c == CH_RPAREN && chan_idx_reg == 2'd2)
                begin
                    phase_next = PH_CLOSED;
                end
                else
                begin
                    phase_next = PH_FAIL;
                end
            end
            default: phase_next = PH_FAIL;
        endcase
    end

    // Build the result from the advanced state
    always_comb
    begin
        form_next  = FORM_NONE;
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        priority if (phase_next == PH_HEX && hex_cnt_next == 3'd6)
        begin
            form_next  = FORM_HEX6;
            red_next   = hex_acc_next[23:16];
            green_next = hex_acc_next[15:8];
            blue_next  = hex_acc_next[7:0];
        end
        else if (phase_next == PH_HEX && hex_cnt_next == 3'd3)
        begin
            form_next  = FORM_HEX3;
            red_next   = {hex_acc_next[11:8], hex_acc_next[11:8]};
            green_next = {hex_acc_next[7:4], hex_acc_next[7:4]};
            blue_next  = {hex_acc_next[3:0], hex_acc_next[3:0]};
        end
        else if (phase_next == PH_CLOSED)
        begin
            form_next  = FORM_RGB;
            red_next   = red_hold_next;
            green_next = green_hold_next;
            blue_next  = dec_acc_next[7:0];
        end
        else
        begin
            form_next = FORM_NONE;
        end
        matched_next = (form_next != FORM_NONE);
    end

    // Capture the incoming request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            stage_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            char_reg <= chars.char_code;
            last_reg <= chars.last_char;
        end
    end

    // Update the parse state; drop back to start of string after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            hex_cnt_reg    <= '0;
            hex_acc_reg    <= '0;
            dec_acc_reg    <= '0;
            dec_cnt_reg    <= '0;
            chan_idx_reg   <= '0;
            red_hold_reg   <= '0;
            green_hold_reg <= '0;
        end
        else if (step)
        begin
            if (last_reg)
            begin
                phase_reg      <= PH_START;
                hex_cnt_reg    <= '0;
                hex_acc_reg    <= '0;
                dec_acc_reg    <= '0;
                dec_cnt_reg    <= '0;
                chan_idx_reg   <= '0;
                red_hold_reg   <= '0;
                green_hold_reg <= '0;
            end
            else
            begin
                phase_reg      <= phase_next;
                hex_cnt_reg    <= hex_cnt_next;
                hex_acc_reg    <= hex_acc_next;
                dec_acc_reg    <= dec_acc_next;
                dec_cnt_reg    <= dec_cnt_next;
                chan_idx_reg   <= chan_idx_next;
                red_hold_reg   <= red_hold_next;
                green_hold_reg <= green_hold_next;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (colors.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && last_reg)
        begin
            matched_reg <= matched_next;
            form_reg    <= form_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
        end
    end

    // Checks
    a_match_form: assert property (@(posedge clk) disable iff (!rst_n)
        colors.valid |-> (colors.matched == (colors.form != FORM_NONE)))
        else $error("matched flag disagrees with form");

    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (colors.valid && !colors.matched) |->
            (colors.red == 8'd0 && colors.green == 8'd0 && colors.blue == 8'd0))
        else $error("unmatched result carries nonzero channels");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last_reg) |=> (phase_reg == PH_START && hex_cnt_reg == 3'd0
                                && chan_idx_reg == 2'd0 && out_valid_reg))
        else $error("state not back to start after last character");

    a_mid_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !last_reg) |-> chars.ready)
        else $error("stall on a character that makes no result");

    a_hex_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        hex_cnt_reg <= 3'd6)
        else $error("hex digit count out of range");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench
    import csp_pkg::*;
;

    localparam int unsigned RANDOM_CHARS = 1400;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef char_t text_t[$];

    typedef struct packed {
        logic  matched;
        form_t form;
        chan_t red;
        chan_t green;
        chan_t blue;
    } color_t;

    typedef enum logic [3:0] {
        P_START, P_HASH, P_HEX, P_R, P_RG, P_RGB,
        P_PRE_NUM, P_NUM, P_POST_NUM, P_CLOSED, P_FAIL
    } parse_phase_e;

    typedef enum int unsigned {
        PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH
    } pace_e;

    logic clk = 1'b0;
    logic rst_n;

    csp_in_if  chars_if();
    csp_out_if colors_if();

    color_string_parser u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .colors (colors_if)
    );

    // Parser state as this testbench sees it
    parse_phase_e phase;
    logic [2:0]   hex_count;
    logic [23:0]  hex_acc;
    logic [9:0]   dec_acc;
    logic [1:0]   dec_count;
    logic [1:0]   chan_idx;
    chan_t        red_hold;
    chan_t        green_hold;

    color_t       pending_colors[$];
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;
    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL color_string_parser");
        $finish;
    end

    // Return the parser to start of string
    function automatic void clear_parse();
        phase      = P_START;
        hex_count  = '0;
        hex_acc    = '0;
        dec_acc    = '0;
        dec_count  = '0;
        chan_idx   = '0;
        red_hold   = '0;
        green_hold = '0;
    endfunction

    // Handle the character that follows a decimal number
    function automatic parse_phase_e close_number(input char_t c);
        if (c == CH_COMMA && chan_idx < 2'd2)
        begin
            if (chan_idx == 2'd0)
                red_hold = dec_acc[7:0];
            else
                green_hold = dec_acc[7:0];
            chan_idx++;
            dec_acc   = '0;
            dec_count = '0;
            return P_PRE_NUM;
        end
        if (c == CH_RPAREN && chan_idx == 2'd2)
            return P_CLOSED;
        return P_FAIL;
    endfunction

    // Advance the parse by one accepted character; queue the color on the last one
    function automatic void parse_step(input char_t code, input logic last);
        char_t      c;
        logic       is_dig;
        logic       is_hex;
        logic       is_ws;
        logic [3:0] nib;
        color_t     res;
        c      = (code >= CH_LA && code <= CH_LZ) ? char_t'(code - CASE_GAP) : code;
        is_dig = (c >= CH_ZERO && c <= CH_NINE);
        is_hex = is_dig || (c >= CH_UA && c <= CH_UF);
        is_ws  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        nib    = is_dig ? 4'(c - CH_ZERO) : 4'(c - CH_UA + 8'd10);
        case (phase)
            P_START, P_HASH, P_HEX:
            begin
                if (phase == P_START && c == CH_HASH)
                    phase = P_HASH;
                else if (phase == P_START && c == CH_UR)
                    phase = P_R;
                else if (is_hex && hex_count < 3'd6)
                begin
                    hex_acc = {hex_acc[19:0], nib};
                    hex_count++;
                    phase = P_HEX;
                end
                else
                    phase = P_FAIL;
            end
            P_R:   phase = (c == CH_UG) ? P_RG : P_FAIL;
            P_RG:  phase = (c == CH_UB) ? P_RGB : P_FAIL;
            P_RGB: phase = (c == CH_LPAREN) ? P_PRE_NUM : P_FAIL;
            P_PRE_NUM:
            begin
                if (is_dig)
                begin
                    dec_acc   = 10'(c - CH_ZERO);
                    dec_count = 2'd1;
                    phase     = P_NUM;
                end
                else if (!is_ws)
                    phase = P_FAIL;
            end
            P_NUM:
            begin
                if (is_dig)
                begin
                    if (dec_count < 2'd3)
                    begin
                        dec_acc = dec_acc * 10'd10 + 10'(c - CH_ZERO);
                        dec_count++;
                    end
                    else
                        phase = P_FAIL;
                end
                else if (is_ws)
                    phase = P_POST_NUM;
                else
                    phase = close_number(c);
            end
            P_POST_NUM:
            begin
                if (!is_ws)
                    phase = close_number(c);
            end
            default: phase = P_FAIL;
        endcase

        if (last)
        begin
            res = '{matched: 1'b0, form: FORM_NONE, red: '0, green: '0, blue: '0};
            if (phase == P_HEX && hex_count == 3'd6)
                res = '{1'b1, FORM_HEX6, hex_acc[23:16], hex_acc[15:8], hex_acc[7:0]};
            else if (phase == P_HEX && hex_count == 3'd3)
            begin
                res.matched = 1'b1;
                res.form    = FORM_HEX3;
                res.red     = hex_acc[11:8] * 8'd17;
                res.green   = hex_acc[7:4] * 8'd17;
                res.blue    = hex_acc[3:0] * 8'd17;
            end
            else if (phase == P_CLOSED)
                res = '{1'b1, FORM_RGB, red_hold, green_hold, dec_acc[7:0]};
            pending_colors.push_back(res);
            clear_parse();
        end
    endfunction

    function automatic void set_pace(input pace_e pace);
        case (pace)
            PACE_SEND_IDLE:  begin send_idle_pct = 58; recv_stall_pct = 0;  end
            PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            PACE_BOTH:       begin send_idle_pct = 11; recv_stall_pct = 11; end
            default:         begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endfunction

    function automatic text_t text_of(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(char_t'(s[i]));
        return t;
    endfunction

    function automatic char_t rand_case(input char_t c);
        return ($urandom_range(1) == 1) ? char_t'(c + CASE_GAP) : c;
    endfunction

    function automatic char_t rand_space();
        int unsigned v;
        v = $urandom_range(5);
        return (v == 5) ? CH_SPACE : char_t'(CH_TAB + v);
    endfunction

    // Present one character and hold it until the request is taken
    task automatic send_char(input char_t code, input logic last);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            chars_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        chars_if.valid     <= 1'b1;
        chars_if.char_code <= code;
        chars_if.last_char <= last;
        do
            @(posedge clk);
        while (!chars_if.ready);
        parse_step(code, last);
    endtask

    task automatic send_text(input text_t t);
        foreach (t[i])
            send_char(t[i], i == t.size() - 1);
    endtask

    task automatic test_six_hex();
        set_pace(PACE_FULL);
        send_text(text_of("#a0F9e1"));
    endtask

    task automatic test_three_hex();
        set_pace(PACE_FULL);
        send_text(text_of("0f9"));
    endtask

    // Whitespace of both kinds, and 300 wraps to 44
    task automatic test_rgb_function();
        set_pace(PACE_FULL);
        send_text(text_of("Rgb(300,\t0 ,255\015)"));
    endtask

    // Seventh hex digit, fourth decimal digit, high byte, early end
    task automatic test_mismatch();
        text_t t;
        set_pace(PACE_BOTH);
        send_text(text_of("1234567"));
        send_text(text_of("rgb(1000)"));
        t = {};
        t.push_back(8'hFF);
        send_text(t);
        send_text(text_of("#"));
    endtask

    task automatic test_random_strings();
        text_t       t;
        int unsigned sent;
        int unsigned strings;
        int unsigned kind;
        int unsigned form_pick;
        int unsigned nib;
        int unsigned pos;
        sent    = 0;
        strings = 0;
        while (sent < RANDOM_CHARS)
        begin
            set_pace(pace_e'((strings / 10) % 4));
            t         = {};
            kind      = $urandom_range(99);
            form_pick = $urandom_range(2);

            // Build a well-formed string of a random form
            if (form_pick < 2)
            begin
                if ($urandom_range(1) == 1)
                    t.push_back(CH_HASH);
                repeat ((form_pick == 0) ? 6 : 3)
                begin
                    nib = $urandom_range(15);
                    if (nib < 10)
                        t.push_back(char_t'(CH_ZERO + nib));
                    else
                        t.push_back(rand_case(char_t'(CH_UA + nib - 10)));
                end
            end
            else
            begin
                t.push_back(rand_case(CH_UR));
                t.push_back(rand_case(CH_UG));
                t.push_back(rand_case(CH_UB));
                t.push_back(CH_LPAREN);
                for (int n = 0; n < 3; n++)
                begin
                    while ($urandom_range(3) == 0)
                        t.push_back(rand_space());
                    repeat ($urandom_range(1, 3))
                        t.push_back(char_t'(CH_ZERO + $urandom_range(9)));
                    while ($urandom_range(3) == 0)
                        t.push_back(rand_space());
                    t.push_back((n == 2) ? CH_RPAREN : CH_COMMA);
                end
            end

            // Break about a quarter: corrupt, truncate, duplicate, or replace with noise
            if (kind < 25)
            begin
                pos = $urandom_range(t.size() - 1);
                case (kind % 4)
                    0: t[pos] = char_t'($urandom_range(255));
                    1: repeat (t.size() - 1 - pos) void'(t.pop_back());
                    2: t.insert(pos, t[pos]);
                    default:
                    begin
                        t = {};
                        repeat ($urandom_range(1, 8))
                            t.push_back(char_t'($urandom_range(255)));
                    end
                endcase
            end

            send_text(t);
            sent += t.size();
            strings++;
        end
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Check each taken result request against the oldest expected color; drive ready
    always @(posedge clk)
    begin
        color_t want;
        if (rst_n && colors_if.valid && colors_if.ready)
        begin
            if (pending_colors.size() == 0)
            begin
                $error("result with no color expected");
                error_count++;
            end
            else
            begin
                want = pending_colors.pop_front();
                check_field("matched", 8'(want.matched), 8'(colors_if.matched));
                check_field("form", 8'(want.form), 8'(colors_if.form));
                check_field("red", want.red, colors_if.red);
                check_field("green", want.green, colors_if.green);
                check_field("blue", want.blue, colors_if.blue);
            end
        end
        colors_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        rst_n              <= 1'b0;
        chars_if.valid     <= 1'b0;
        chars_if.char_code <= '0;
        chars_if.last_char <= 1'b0;
        clear_parse();
        set_pace(PACE_FULL);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_six_hex();
        test_three_hex();
        test_rgb_function();
        test_mismatch();
        test_random_strings();

        // Drain outstanding colors, then let the pipeline settle
        chars_if.valid <= 1'b0;
        set_pace(PACE_FULL);
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("PASS color_string_parser");
        else
            $display("FAIL color_string_parser");
        $finish;
    end

endmodule

[files.f]
rtl/csp_pkg.sv
rtl/csp_if.sv
rtl/color_string_parser.sv
test/testbench.sv
